// File: hdl/gcsu_pkg.sv
`timescale 1ns / 1ps
package gcsu_pkg;

   localparam int DEF_VALUE_WIDTH    = 32;
   localparam int DEF_FRAC_BITS      = 16;
   // Scale of the register factors (spacing, time step, edge weight).
   localparam int SPEC_FRAC          = 16;
   localparam int TAP_W              = 32;
   localparam int SPACING_W          = 24;
   localparam int STEP_W             = 17;
   localparam int WEIGHT_W           = 17;
   localparam int CSR_INDEX_W        = 2;
   localparam int CSR_DATA_W         = 24;
   localparam int DIV_BITS_PER_STAGE = 4;
   localparam int FRONT_STAGES       = 5;
   localparam int TAIL_STAGES        = 4;

   localparam logic [SPACING_W-1:0] INV_SPACING_RESET = 24'd65536;
   localparam logic [STEP_W-1:0]    TIME_STEP_RESET   = 17'd6554;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INV_SPACING_X = 2'd0,
      CSR_INV_SPACING_Y = 2'd1,
      CSR_TIME_STEP     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic clip;
   } stage_ctl_type;

endpackage

// File: hdl/geodesic_curvature_stencil_update.sv
`timescale 1ns / 1ps
// An accepted input beat passes the input register, the front stages, the quotient
// stages and the tail stages. Throughput: one pixel per cycle while the result is
// not stalled; the quotient is built four bits per pipeline stage.
// A stalled result holds the whole pipeline, so nothing is dropped or repeated.
// Reset (synchronous) empties the pipeline and loads the default spacing and time step.
module geodesic_curvature_stencil_update import gcsu_pkg::*; #(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [TAP_W-1:0] req_phi_center,
   input  logic signed [TAP_W-1:0] req_phi_west,
   input  logic signed [TAP_W-1:0] req_phi_east,
   input  logic signed [TAP_W-1:0] req_phi_north,
   input  logic signed [TAP_W-1:0] req_phi_south,
   input  logic signed [TAP_W-1:0] req_phi_south_east,
   input  logic signed [TAP_W-1:0] req_phi_north_west,
   input  logic signed [TAP_W-1:0] req_phi_north_east,
   input  logic signed [TAP_W-1:0] req_phi_south_west,
   input  logic [WEIGHT_W-1:0]     req_edge_weight,
   input  logic signed [TAP_W-1:0] req_edge_grad_x,
   input  logic signed [TAP_W-1:0] req_edge_grad_y,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [TAP_W-1:0] rsp_phi_next,
   output logic                    rsp_saturated,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int W          = VALUE_WIDTH;
   localparam int W1         = W + 1;
   localparam int GW_S       = WEIGHT_W + 1;
   localparam int TS_S       = STEP_W + 1;
   localparam int N_IN       = 11;
   localparam int DIV_STAGES = (W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
   localparam int PIPE_DEPTH = 1 + FRONT_STAGES + DIV_STAGES + TAIL_STAGES;
   localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);
   localparam int SIDE_F_W   = W + WEIGHT_W;
   localparam int SIDE_D_W   = 2 * W + WEIGHT_W;

   localparam int IDX_C  = 0;
   localparam int IDX_W  = 1;
   localparam int IDX_E  = 2;
   localparam int IDX_N  = 3;
   localparam int IDX_S  = 4;
   localparam int IDX_SE = 5;
   localparam int IDX_NW = 6;
   localparam int IDX_NE = 7;
   localparam int IDX_SW = 8;
   localparam int IDX_GX = 9;
   localparam int IDX_GY = 10;

   logic adv;

   // The pipeline moves whenever the output register is empty or being drained.
   assign adv       = ~rsp_valid | ~rsp_stall;
   assign req_stall = ~adv;

   // ---------------- configuration registers ----------------
   logic [SPACING_W-1:0] inv_x_ff, inv_y_ff;
   logic [STEP_W-1:0]    ts_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_x_ff <= INV_SPACING_RESET;
         inv_y_ff <= INV_SPACING_RESET;
         ts_ff    <= TIME_STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_INV_SPACING_X: inv_x_ff <= csr_data[SPACING_W-1:0];
            CSR_INV_SPACING_Y: inv_y_ff <= csr_data[SPACING_W-1:0];
            CSR_TIME_STEP:     ts_ff    <= csr_data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- input stage: clamp taps to the working width ----------------
   logic signed [TAP_W-1:0] raw_in [N_IN];
   logic signed [W-1:0]     sat_in [N_IN];
   logic signed [W-1:0]     val_ff [N_IN];
   logic [N_IN-1:0]         in_clip;
   logic [WEIGHT_W-1:0]     gw0_ff;
   stage_ctl_type           ctl0_in, ctl0_ff;

   assign raw_in[IDX_C]  = req_phi_center;
   assign raw_in[IDX_W]  = req_phi_west;
   assign raw_in[IDX_E]  = req_phi_east;
   assign raw_in[IDX_N]  = req_phi_north;
   assign raw_in[IDX_S]  = req_phi_south;
   assign raw_in[IDX_SE] = req_phi_south_east;
   assign raw_in[IDX_NW] = req_phi_north_west;
   assign raw_in[IDX_NE] = req_phi_north_east;
   assign raw_in[IDX_SW] = req_phi_south_west;
   assign raw_in[IDX_GX] = req_edge_grad_x;
   assign raw_in[IDX_GY] = req_edge_grad_y;

   generate
      for (genvar i = 0; i < N_IN; i++) begin : g_in_sat
         gcsu_sat #(.IN_W(TAP_W), .OUT_W(W)) u_sat (
            .din(raw_in[i]), .dout(sat_in[i]), .clip(in_clip[i]));
      end
   endgenerate

   always_comb begin
      ctl0_in.valid = req_valid;
      ctl0_in.clip  = |in_clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
      end else if (adv) begin
         ctl0_ff <= ctl0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < N_IN; i++) begin
            val_ff[i] <= sat_in[i];
         end
         gw0_ff <= req_edge_weight;
      end
   end

   // ---------------- differences and curvature terms ----------------
   stage_ctl_type       f_ctl;
   logic signed [W-1:0] f_num, f_den, f_up;
   logic [SIDE_F_W-1:0] f_side;

   gcsu_front #(
      .VALUE_WIDTH (W),
      .FRAC_BITS   (FRAC_BITS),
      .SIDE_W      (SIDE_F_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_ctl   (ctl0_ff),
      .phi_c    (val_ff[IDX_C]),
      .phi_w    (val_ff[IDX_W]),
      .phi_e    (val_ff[IDX_E]),
      .phi_n    (val_ff[IDX_N]),
      .phi_s    (val_ff[IDX_S]),
      .phi_se   (val_ff[IDX_SE]),
      .phi_nw   (val_ff[IDX_NW]),
      .phi_ne   (val_ff[IDX_NE]),
      .phi_sw   (val_ff[IDX_SW]),
      .grad_x   (val_ff[IDX_GX]),
      .grad_y   (val_ff[IDX_GY]),
      .inv_x    (inv_x_ff),
      .inv_y    (inv_y_ff),
      .side_in  ({val_ff[IDX_C], gw0_ff}),
      .out_ctl  (f_ctl),
      .num      (f_num),
      .den      (f_den),
      .up       (f_up),
      .side_out (f_side)
   );

   // ---------------- curvature quotient ----------------
   stage_ctl_type       d_ctl;
   logic [W-1:0]        d_quo;
   logic                d_neg;
   logic [SIDE_D_W-1:0] d_side;
   logic signed [W-1:0] d_c, d_up;
   logic [WEIGHT_W-1:0] d_gw;

   gcsu_div #(
      .VALUE_WIDTH (W),
      .FRAC_BITS   (FRAC_BITS),
      .SIDE_W      (SIDE_D_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_ctl   (f_ctl),
      .num      (f_num),
      .den      (f_den),
      .side_in  ({f_side[SIDE_F_W-1:WEIGHT_W], f_up, f_side[WEIGHT_W-1:0]}),
      .out_ctl  (d_ctl),
      .quo      (d_quo),
      .neg      (d_neg),
      .side_out (d_side)
   );

   assign d_c  = d_side[SIDE_D_W-1:W+WEIGHT_W];
   assign d_up = d_side[W+WEIGHT_W-1:WEIGHT_W];
   assign d_gw = d_side[WEIGHT_W-1:0];

   // ---------------- tail 1: signed quotient times edge weight ----------------
   logic signed [W1-1:0] hq_raw;
   logic signed [W-1:0]  hq;
   logic signed [W-1:0]  hg_in, hg_ff, up_t1_ff, c_t1_ff;
   logic signed [GW_S-1:0] gw_s;
   logic [1:0]           clip_t1;
   stage_ctl_type        ctl_t1_in, ctl_t1_ff;

   assign hq_raw = d_neg ? -$signed({1'b0, d_quo}) : $signed({1'b0, d_quo});
   assign gw_s   = {1'b0, d_gw};

   gcsu_sat #(.IN_W(W1), .OUT_W(W)) u_hq (
      .din(hq_raw), .dout(hq), .clip(clip_t1[0]));
   gcsu_mul #(.A_W(GW_S), .B_W(W), .SHIFT(SPEC_FRAC), .OUT_W(W)) u_hg (
      .a(gw_s), .b(hq), .p(hg_in), .clip(clip_t1[1]));

   always_comb begin
      ctl_t1_in.valid = d_ctl.valid;
      ctl_t1_in.clip  = d_ctl.clip | (|clip_t1);
   end

   // ---------------- tail 2: curvature minus advection ----------------
   logic signed [W-1:0] diff_in, diff_ff, c_t2_ff;
   logic                clip_t2;
   stage_ctl_type       ctl_t2_in, ctl_t2_ff;

   gcsu_sat #(.IN_W(W1), .OUT_W(W)) u_diff (
      .din(W1'(hg_ff) - W1'(up_t1_ff)), .dout(diff_in), .clip(clip_t2));

   always_comb begin
      ctl_t2_in.valid = ctl_t1_ff.valid;
      ctl_t2_in.clip  = ctl_t1_ff.clip | clip_t2;
   end

   // ---------------- tail 3: time step ----------------
   logic signed [TS_S-1:0] ts_s;
   logic signed [W-1:0]    step_in, step_ff, c_t3_ff;
   logic                   clip_t3;
   stage_ctl_type          ctl_t3_in, ctl_t3_ff;

   assign ts_s = {1'b0, ts_ff};

   gcsu_mul #(.A_W(TS_S), .B_W(W), .SHIFT(SPEC_FRAC), .OUT_W(W)) u_step (
      .a(ts_s), .b(diff_ff), .p(step_in), .clip(clip_t3));

   always_comb begin
      ctl_t3_in.valid = ctl_t2_ff.valid;
      ctl_t3_in.clip  = ctl_t2_ff.clip | clip_t3;
   end

   // ---------------- tail 4: update and output register ----------------
   logic signed [W-1:0]     nxt_w;
   logic signed [TAP_W-1:0] nxt_in, phi_out_ff;
   logic [1:0]              clip_t4;
   stage_ctl_type           ctl_out_in, ctl_out_ff;

   gcsu_sat #(.IN_W(W1), .OUT_W(W)) u_nxt (
      .din(W1'(c_t3_ff) + W1'(step_ff)), .dout(nxt_w), .clip(clip_t4[0]));
   gcsu_sat #(.IN_W(W), .OUT_W(TAP_W)) u_out (
      .din(nxt_w), .dout(nxt_in), .clip(clip_t4[1]));

   always_comb begin
      ctl_out_in.valid = ctl_t3_ff.valid;
      ctl_out_in.clip  = ctl_t3_ff.clip | (|clip_t4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_t1_ff  <= '0;
         ctl_t2_ff  <= '0;
         ctl_t3_ff  <= '0;
         ctl_out_ff <= '0;
      end else if (adv) begin
         ctl_t1_ff  <= ctl_t1_in;
         ctl_t2_ff  <= ctl_t2_in;
         ctl_t3_ff  <= ctl_t3_in;
         ctl_out_ff <= ctl_out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hg_ff      <= hg_in;
         up_t1_ff   <= d_up;
         c_t1_ff    <= d_c;
         diff_ff    <= diff_in;
         c_t2_ff    <= c_t1_ff;
         step_ff    <= step_in;
         c_t3_ff    <= c_t2_ff;
         phi_out_ff <= nxt_in;
      end
   end

   assign rsp_valid     = ctl_out_ff.valid;
   assign rsp_saturated = ctl_out_ff.clip;
   assign rsp_phi_next  = phi_out_ff;

   // ---------------- checks ----------------
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             beat_in, beat_out;

   assign beat_in  = req_valid & ~req_stall;
   assign beat_out = rsp_valid & ~rsp_stall;
   assign occ_in   = occ_ff + OCC_W'(beat_in) - OCC_W'(beat_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(PIPE_DEPTH))
      else $error("more beats in flight than pipeline stages");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> occ_ff != '0)
      else $error("result beat with no accepted input beat behind it");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(ctl_t1_ff) && $stable(hg_ff)))
      else $error("pipeline moved while the result was stalled");

endmodule

// File: hdl/gcsu_sat.sv
`timescale 1ns / 1ps
module gcsu_sat #(
   parameter int IN_W  = 33,
   parameter int OUT_W = 32
) (
   input  logic signed [IN_W-1:0]  din,
   output logic signed [OUT_W-1:0] dout,
   output logic                    clip
);

   generate
      if (OUT_W >= IN_W) begin : g_widen
         assign dout = OUT_W'(din);
         assign clip = 1'b0;
      end else begin : g_narrow
         logic [IN_W-OUT_W:0] top_bits;
         logic                fits;

         // The value fits when every bit above the target sign bit repeats it.
         assign top_bits = din[IN_W-1:OUT_W-1];
         assign fits     = (&top_bits) | ~(|top_bits);
         assign clip     = ~fits;

         always_comb begin
            if (fits) begin
               dout = din[OUT_W-1:0];
            end else if (din[IN_W-1]) begin
               dout = {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
               dout = {1'b0, {(OUT_W-1){1'b1}}};
            end
         end
      end
   endgenerate

endmodule

// File: hdl/gcsu_mul.sv
`timescale 1ns / 1ps
module gcsu_mul #(
   parameter int A_W   = 32,
   parameter int B_W   = 32,
   parameter int SHIFT = 16,
   parameter int OUT_W = 32
) (
   input  logic signed [A_W-1:0]   a,
   input  logic signed [B_W-1:0]   b,
   output logic signed [OUT_W-1:0] p,
   output logic                    clip
);

   localparam int P_W = A_W + B_W;

   logic signed [P_W-1:0] prod;
   logic signed [P_W-1:0] shifted;

   // Arithmetic shift of the full product rounds toward minus infinity.
   assign prod    = P_W'(a) * P_W'(b);
   assign shifted = prod >>> SHIFT;

   gcsu_sat #(.IN_W(P_W), .OUT_W(OUT_W)) u_sat (
      .din  (shifted),
      .dout (p),
      .clip (clip)
   );

endmodule

// File: hdl/gcsu_front.sv
`timescale 1ns / 1ps
module gcsu_front import gcsu_pkg::*; #(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   parameter int FRAC_BITS   = DEF_FRAC_BITS,
   parameter int SIDE_W      = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  stage_ctl_type                 in_ctl,
   input  logic signed [VALUE_WIDTH-1:0] phi_c,
   input  logic signed [VALUE_WIDTH-1:0] phi_w,
   input  logic signed [VALUE_WIDTH-1:0] phi_e,
   input  logic signed [VALUE_WIDTH-1:0] phi_n,
   input  logic signed [VALUE_WIDTH-1:0] phi_s,
   input  logic signed [VALUE_WIDTH-1:0] phi_se,
   input  logic signed [VALUE_WIDTH-1:0] phi_nw,
   input  logic signed [VALUE_WIDTH-1:0] phi_ne,
   input  logic signed [VALUE_WIDTH-1:0] phi_sw,
   input  logic signed [VALUE_WIDTH-1:0] grad_x,
   input  logic signed [VALUE_WIDTH-1:0] grad_y,
   input  logic [SPACING_W-1:0]          inv_x,
   input  logic [SPACING_W-1:0]          inv_y,
   input  logic [SIDE_W-1:0]             side_in,
   output stage_ctl_type                 out_ctl,
   output logic signed [VALUE_WIDTH-1:0] num,
   output logic signed [VALUE_WIDTH-1:0] den,
   output logic signed [VALUE_WIDTH-1:0] up,
   output logic [SIDE_W-1:0]             side_out
);

   localparam int W  = VALUE_WIDTH;
   localparam int W1 = W + 1;
   localparam int W2 = W + 2;
   localparam int W3 = W + 3;
   localparam int SW = SPACING_W + 1;
   localparam logic signed [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;

   logic signed [SW-1:0] ix_s;
   logic signed [SW-1:0] iy_s;

   assign ix_s = {1'b0, inv_x};
   assign iy_s = {1'b0, inv_y};

   // ---------------- stage 1: raw differences and negated gradients ----------------
   stage_ctl_type        ctl1_in, ctl1_ff;
   logic signed [W1-1:0] cw_in, cn_in, ec_in, sc_in, ew_in, sn_in;
   logic signed [W1-1:0] cw_ff, cn_ff, ec_ff, sc_ff, ew_ff, sn_ff;
   logic signed [W2-1:0] mx_in, mx_ff;
   logic signed [W-1:0]  ngx_in, ngy_in, ngx1_ff, ngy1_ff;
   logic                 ngx_clip, ngy_clip;
   logic [SIDE_W-1:0]    side1_ff;

   assign cw_in = W1'(phi_c) - W1'(phi_w);
   assign cn_in = W1'(phi_c) - W1'(phi_n);
   assign ec_in = W1'(phi_e) - W1'(phi_c);
   assign sc_in = W1'(phi_s) - W1'(phi_c);
   assign ew_in = W1'(phi_e) - W1'(phi_w);
   assign sn_in = W1'(phi_s) - W1'(phi_n);
   assign mx_in = W2'(phi_se) + W2'(phi_nw) - W2'(phi_ne) - W2'(phi_sw);

   gcsu_sat #(.IN_W(W1), .OUT_W(W)) u_ngx (
      .din(-W1'(grad_x)), .dout(ngx_in), .clip(ngx_clip));
   gcsu_sat #(.IN_W(W1), .OUT_W(W)) u_ngy (
      .din(-W1'(grad_y)), .dout(ngy_in), .clip(ngy_clip));

   always_comb begin
      ctl1_in.valid = in_ctl.valid;
      ctl1_in.clip  = in_ctl.clip | ngx_clip | ngy_clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else if (adv) begin
         ctl1_ff <= ctl1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cw_ff    <= cw_in;
         cn_ff    <= cn_in;
         ec_ff    <= ec_in;
         sc_ff    <= sc_in;
         ew_ff    <= ew_in;
         sn_ff    <= sn_in;
         mx_ff    <= mx_in;
         ngx1_ff  <= ngx_in;
         ngy1_ff  <= ngy_in;
         side1_ff <= side_in;
      end
   end

   // ---------------- stage 2: scaled one-sided and central differences ----------------
   stage_ctl_type       ctl2_in, ctl2_ff;
   logic signed [W-1:0] dmx_in, dmy_in, dpx_in, dpy_in, dx_in, dy_in, t1_in;
   logic signed [W-1:0] dmx_ff, dmy_ff, dpx_ff, dpy_ff, dx_ff, dy_ff, t1_ff;
   logic signed [W-1:0] ngx2_ff, ngy2_ff;
   logic [6:0]          clip2;
   logic [SIDE_W-1:0]   side2_ff;

   gcsu_mul #(.A_W(W1), .B_W(SW), .SHIFT(SPEC_FRAC), .OUT_W(W)) u_dmx (
      .a(cw_ff), .b(ix_s), .p(dmx_in), .clip(clip2[0]));
   gcsu_mul #(.A_W(W1), .B_W(SW), .SHIFT(SPEC_FRAC), .OUT_W(W)) u_dmy (
      .a(cn_ff), .b(iy_s), .p(dmy_in), .clip(clip2[1]));
   gcsu_mul #(.A_W(W1), .B_W(SW), .SHIFT(SPEC_FRAC), .OUT_W(W)) u_dpx (
      .a(ec_ff), .b(ix_s), .p(dpx_in), .clip(clip2[2]));
   gcsu_mul #(.A_W(W1), .B_W(SW), .SHIFT(SPEC_FRAC), .OUT_W(W)) u_dpy (
      .a(sc_ff), .b(iy_s), .p(dpy_in), .clip(clip2[3]));
   gcsu_mul #(.A_W(W1), .B_W(SW), .SHIFT(SPEC_FRAC + 1), .OUT_W(W)) u_dx (
      .a(ew_ff), .b(ix_s), .p(dx_in), .clip(clip2[4]));
   gcsu_mul #(.A_W(W1), .B_W(SW), .SHIFT(SPEC_FRAC + 1), .OUT_W(W)) u_dy (
      .a(sn_ff), .b(iy_s), .p(dy_in), .clip(clip2[5]));
   gcsu_mul #(.A_W(W2), .B_W(SW), .SHIFT(SPEC_FRAC), .OUT_W(W)) u_t1 (
      .a(mx_ff), .b(ix_s), .p(t1_in), .clip(clip2[6]));

   always_comb begin
      ctl2_in.valid = ctl1_ff.valid;
      ctl2_in.clip  = ctl1_ff.clip | (|clip2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else if (adv) begin
         ctl2_ff <= ctl2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dmx_ff   <= dmx_in;
         dmy_ff   <= dmy_in;
         dpx_ff   <= dpx_in;
         dpy_ff   <= dpy_in;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         t1_ff    <= t1_in;
         ngx2_ff  <= ngx1_ff;
         ngy2_ff  <= ngy1_ff;
         side2_ff <= side1_ff;
      end
   end

   // ---------------- stage 3: second, mixed and squared terms, upwind ----------------
   stage_ctl_type        ctl3_in, ctl3_ff;
   logic signed [W1-1:0] ddx, ddy;
   logic signed [W-1:0]  ux_sel, uy_sel;
   logic signed [W-1:0]  d2x_in, d2y_in, dxy_in, dxs_in, dys_in, pxy_in, ux_in, uy_in;
   logic signed [W-1:0]  d2x_ff, d2y_ff, dxy_ff, dxs_ff, dys_ff, pxy_ff, ux_ff, uy_ff;
   logic [7:0]           clip3;
   logic [SIDE_W-1:0]    side3_ff;

   assign ddx = W1'(dpx_ff) - W1'(dmx_ff);
   assign ddy = W1'(dpy_ff) - W1'(dmy_ff);
   // A negative speed takes the forward difference, otherwise the backward one.
   assign ux_sel = ngx2_ff[W-1] ? dpx_ff : dmx_ff;
   assign uy_sel = ngy2_ff[W-1] ? dpy_ff : dmy_ff;

   gcsu_mul #(.A_W(W1), .B_W(SW), .SHIFT(SPEC_FRAC), .OUT_W(W)) u_d2x (
      .a(ddx), .b(ix_s), .p(d2x_in), .clip(clip3[0]));
   gcsu_mul #(.A_W(W1), .B_W(SW), .SHIFT(SPEC_FRAC), .OUT_W(W)) u_d2y (
      .a(ddy), .b(iy_s), .p(d2y_in), .clip(clip3[1]));
   gcsu_mul #(.A_W(W), .B_W(SW), .SHIFT(SPEC_FRAC + 2), .OUT_W(W)) u_dxy (
      .a(t1_ff), .b(iy_s), .p(dxy_in), .clip(clip3[2]));
   gcsu_mul #(.A_W(W), .B_W(W), .SHIFT(FRAC_BITS), .OUT_W(W)) u_dxs (
      .a(dx_ff), .b(dx_ff), .p(dxs_in), .clip(clip3[3]));
   gcsu_mul #(.A_W(W), .B_W(W), .SHIFT(FRAC_BITS), .OUT_W(W)) u_dys (
      .a(dy_ff), .b(dy_ff), .p(dys_in), .clip(clip3[4]));
   gcsu_mul #(.A_W(W), .B_W(W), .SHIFT(FRAC_BITS), .OUT_W(W)) u_pxy (
      .a(dx_ff), .b(dy_ff), .p(pxy_in), .clip(clip3[5]));
   gcsu_mul #(.A_W(W), .B_W(W), .SHIFT(FRAC_BITS), .OUT_W(W)) u_ux (
      .a(ngx2_ff), .b(ux_sel), .p(ux_in), .clip(clip3[6]));
   gcsu_mul #(.A_W(W), .B_W(W), .SHIFT(FRAC_BITS), .OUT_W(W)) u_uy (
      .a(ngy2_ff), .b(uy_sel), .p(uy_in), .clip(clip3[7]));

   always_comb begin
      ctl3_in.valid = ctl2_ff.valid;
      ctl3_in.clip  = ctl2_ff.clip | (|clip3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
      end else if (adv) begin
         ctl3_ff <= ctl3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d2x_ff   <= d2x_in;
         d2y_ff   <= d2y_in;
         dxy_ff   <= dxy_in;
         dxs_ff   <= dxs_in;
         dys_ff   <= dys_in;
         pxy_ff   <= pxy_in;
         ux_ff    <= ux_in;
         uy_ff    <= uy_in;
         side3_ff <= side2_ff;
      end
   end

   // ---------------- stage 4: numerator terms, denominator, upwind sum ----------------
   stage_ctl_type       ctl4_in, ctl4_ff;
   logic signed [W-1:0] fx, fy;
   logic signed [W-1:0] a1_in, a2_in, a3_in, den_in, up_in;
   logic signed [W-1:0] a1_ff, a2_ff, a3_ff, den4_ff, up4_ff;
   logic [6:0]          clip4;
   logic [SIDE_W-1:0]   side4_ff;

   gcsu_sat #(.IN_W(W1), .OUT_W(W)) u_fx (
      .din(W1'(ONE) + W1'(dxs_ff)), .dout(fx), .clip(clip4[0]));
   gcsu_sat #(.IN_W(W1), .OUT_W(W)) u_fy (
      .din(W1'(ONE) + W1'(dys_ff)), .dout(fy), .clip(clip4[1]));
   gcsu_mul #(.A_W(W), .B_W(W), .SHIFT(FRAC_BITS), .OUT_W(W)) u_a1 (
      .a(fx), .b(d2y_ff), .p(a1_in), .clip(clip4[2]));
   gcsu_mul #(.A_W(W), .B_W(W), .SHIFT(FRAC_BITS), .OUT_W(W)) u_a2 (
      .a(fy), .b(d2x_ff), .p(a2_in), .clip(clip4[3]));
   gcsu_mul #(.A_W(W), .B_W(W), .SHIFT(FRAC_BITS), .OUT_W(W)) u_a3 (
      .a(pxy_ff), .b(dxy_ff), .p(a3_in), .clip(clip4[4]));
   gcsu_sat #(.IN_W(W2), .OUT_W(W)) u_den (
      .din(W2'(ONE) + W2'(dxs_ff) + W2'(dys_ff)), .dout(den_in), .clip(clip4[5]));
   gcsu_sat #(.IN_W(W1), .OUT_W(W)) u_up (
      .din(W1'(ux_ff) + W1'(uy_ff)), .dout(up_in), .clip(clip4[6]));

   always_comb begin
      ctl4_in.valid = ctl3_ff.valid;
      ctl4_in.clip  = ctl3_ff.clip | (|clip4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff <= '0;
      end else if (adv) begin
         ctl4_ff <= ctl4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff    <= a1_in;
         a2_ff    <= a2_in;
         a3_ff    <= a3_in;
         den4_ff  <= den_in;
         up4_ff   <= up_in;
         side4_ff <= side3_ff;
      end
   end

   // ---------------- stage 5: curvature numerator ----------------
   stage_ctl_type       ctl5_in, ctl5_ff;
   logic signed [W-1:0] num_in, num_ff, den5_ff, up5_ff;
   logic                num_clip;
   logic [SIDE_W-1:0]   side5_ff;

   gcsu_sat #(.IN_W(W3), .OUT_W(W)) u_num (
      .din(W3'(a1_ff) + W3'(a2_ff) - (W3'(a3_ff) <<< 1)),
      .dout(num_in), .clip(num_clip));

   always_comb begin
      ctl5_in.valid = ctl4_ff.valid;
      ctl5_in.clip  = ctl4_ff.clip | num_clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl5_ff <= '0;
      end else if (adv) begin
         ctl5_ff <= ctl5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff   <= num_in;
         den5_ff  <= den4_ff;
         up5_ff   <= up4_ff;
         side5_ff <= side4_ff;
      end
   end

   assign out_ctl  = ctl5_ff;
   assign num      = num_ff;
   assign den      = den5_ff;
   assign up       = up5_ff;
   assign side_out = side5_ff;

endmodule

// File: hdl/gcsu_div.sv
`timescale 1ns / 1ps
module gcsu_div import gcsu_pkg::*; #(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   parameter int FRAC_BITS   = DEF_FRAC_BITS,
   parameter int SIDE_W      = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  stage_ctl_type                 in_ctl,
   input  logic signed [VALUE_WIDTH-1:0] num,
   input  logic signed [VALUE_WIDTH-1:0] den,
   input  logic [SIDE_W-1:0]             side_in,
   output stage_ctl_type                 out_ctl,
   output logic [VALUE_WIDTH-1:0]        quo,
   output logic                          neg,
   output logic [SIDE_W-1:0]             side_out
);

   localparam int W      = VALUE_WIDTH;
   localparam int K      = DIV_BITS_PER_STAGE;
   localparam int STAGES = (W + K - 1) / K;

   logic [W-1:0] mag;
   logic [W-1:0] rem_entry;
   logic [W-1:0] dvd_entry;

   // The dividend is |num| with FRAC_BITS zeros appended. The quotient fits in W bits
   // because the divisor is at least one, so the top FRAC_BITS dividend bits start
   // out as the partial remainder and the rest are shifted in one per step.
   assign mag       = num[W-1] ? W'(-num) : W'(num);
   assign rem_entry = mag >> (W - FRAC_BITS);
   assign dvd_entry = mag << FRAC_BITS;

   stage_ctl_type     ctl_ff  [STAGES];
   logic [W-1:0]      rem_ff  [STAGES];
   logic [W-1:0]      dvd_ff  [STAGES];
   logic [W-1:0]      quo_ff  [STAGES];
   logic [W-1:0]      den_ff  [STAGES];
   logic              neg_ff  [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];

   generate
      for (genvar s = 0; s < STAGES; s++) begin : g_stage
         stage_ctl_type     ctl_src;
         logic [W-1:0]      rem_src, dvd_src, quo_src, den_src;
         logic              neg_src;
         logic [SIDE_W-1:0] side_src;
         logic [W-1:0]      rem_in, dvd_in, quo_in;

         if (s == 0) begin : g_first
            assign ctl_src  = in_ctl;
            assign rem_src  = rem_entry;
            assign dvd_src  = dvd_entry;
            assign quo_src  = '0;
            assign den_src  = den;
            assign neg_src  = num[W-1];
            assign side_src = side_in;
         end else begin : g_next
            assign ctl_src  = ctl_ff[s-1];
            assign rem_src  = rem_ff[s-1];
            assign dvd_src  = dvd_ff[s-1];
            assign quo_src  = quo_ff[s-1];
            assign den_src  = den_ff[s-1];
            assign neg_src  = neg_ff[s-1];
            assign side_src = side_ff[s-1];
         end

         always_comb begin
            logic [W:0]   trial;
            logic [W-1:0] r;
            logic [W-1:0] d;
            logic [W-1:0] q;
            r     = rem_src;
            d     = dvd_src;
            q     = quo_src;
            trial = '0;
            for (int k = 0; k < K; k++) begin
               if (s * K + k < W) begin
                  trial = {r, d[W-1]};
                  d     = d << 1;
                  if (trial >= {1'b0, den_src}) begin
                     trial = trial - {1'b0, den_src};
                     q     = {q[W-2:0], 1'b1};
                  end else begin
                     q     = {q[W-2:0], 1'b0};
                  end
                  r = trial[W-1:0];
               end
            end
            rem_in = r;
            dvd_in = d;
            quo_in = q;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               ctl_ff[s] <= '0;
            end else if (adv) begin
               ctl_ff[s] <= ctl_src;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[s]  <= rem_in;
               dvd_ff[s]  <= dvd_in;
               quo_ff[s]  <= quo_in;
               den_ff[s]  <= den_src;
               neg_ff[s]  <= neg_src;
               side_ff[s] <= side_src;
            end
         end
      end
   endgenerate

   assign out_ctl  = ctl_ff[STAGES-1];
   assign quo      = quo_ff[STAGES-1];
   assign neg      = neg_ff[STAGES-1];
   assign side_out = side_ff[STAGES-1];

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;
   import gcsu_pkg::*;

   localparam longint Q_ONE = 64'sd65536;
   localparam longint V_MAX = 64'sd2147483647;
   localparam longint V_MIN = -64'sd2147483648;

   typedef struct {
      logic signed [TAP_W-1:0]  phi [9]; // center, w, e, n, s, se, nw, ne, sw
      logic [WEIGHT_W-1:0]      weight;
      logic signed [TAP_W-1:0]  grad_x;
      logic signed [TAP_W-1:0]  grad_y;
   } stencil_type;

   typedef struct {
      logic signed [TAP_W-1:0] phi_next;
      logic                    saturated;
   } update_type;

   typedef struct {
      stencil_type st;
      bit          fixed;
      update_type  want;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [TAP_W-1:0] req_phi [9];
   logic [WEIGHT_W-1:0] req_edge_weight = '0;
   logic signed [TAP_W-1:0] req_edge_grad_x = '0;
   logic signed [TAP_W-1:0] req_edge_grad_y = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [TAP_W-1:0] rsp_phi_next;
   logic rsp_saturated;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   longint spacing_x = 65536, spacing_y = 65536, step_size = 6554;
   bit clip_hit;
   update_type pending_q [$];
   int errors = 0;
   bit quiet = 0;
   bit hold_request = 0;

   initial begin
      for (int i = 0; i < 9; i++) req_phi[i] = '0;
   end

   always #6 clock = ~clock;

   geodesic_curvature_stencil_update dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_phi_center(req_phi[0]), .req_phi_west(req_phi[1]), .req_phi_east(req_phi[2]),
      .req_phi_north(req_phi[3]), .req_phi_south(req_phi[4]),
      .req_phi_south_east(req_phi[5]), .req_phi_north_west(req_phi[6]),
      .req_phi_north_east(req_phi[7]), .req_phi_south_west(req_phi[8]),
      .req_edge_weight(req_edge_weight),
      .req_edge_grad_x(req_edge_grad_x), .req_edge_grad_y(req_edge_grad_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_phi_next(rsp_phi_next), .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   function automatic longint clamp(longint v, int w);
      longint hi;
      hi = (64'sd1 <<< (w - 1)) - 1;
      if (v > hi) begin
         clip_hit = 1;
         return hi;
      end
      if (v < -hi - 1) begin
         clip_hit = 1;
         return -hi - 1;
      end
      return v;
   endfunction

   // Full-width product, floor shift, then clip to the value width.
   function automatic longint scaled_mul(longint a, longint b, int sh);
      logic signed [127:0] pa, pb, p;
      pa = a;
      pb = b;
      p = (pa * pb) >>> sh;
      if (p > V_MAX) begin
         clip_hit = 1;
         return V_MAX;
      end
      if (p < V_MIN) begin
         clip_hit = 1;
         return V_MIN;
      end
      return longint'(p);
   endfunction

   function automatic update_type predict_update(stencil_type st);
      longint p [9];
      longint c, w, e, n, s, dmx, dmy, dpx, dpy, dx, dy, d2x, d2y, dxy, dxs, dys;
      longint num, den, hq, hg, ngx, ngy, ux, uy, up, diff, nxt;
      update_type r;
      clip_hit = 0;
      for (int i = 0; i < 9; i++) p[i] = longint'(st.phi[i]);
      c = p[0]; w = p[1]; e = p[2]; n = p[3]; s = p[4];
      dmx = scaled_mul(c - w, spacing_x, SPEC_FRAC);
      dmy = scaled_mul(c - n, spacing_y, SPEC_FRAC);
      dpx = scaled_mul(e - c, spacing_x, SPEC_FRAC);
      dpy = scaled_mul(s - c, spacing_y, SPEC_FRAC);
      dx = scaled_mul(e - w, spacing_x, SPEC_FRAC + 1);
      dy = scaled_mul(s - n, spacing_y, SPEC_FRAC + 1);
      d2x = scaled_mul(dpx - dmx, spacing_x, SPEC_FRAC);
      d2y = scaled_mul(dpy - dmy, spacing_y, SPEC_FRAC);
      dxy = scaled_mul(scaled_mul(p[5] + p[6] - p[7] - p[8], spacing_x, SPEC_FRAC),
                       spacing_y, SPEC_FRAC + 2);
      dxs = scaled_mul(dx, dx, 16);
      dys = scaled_mul(dy, dy, 16);
      num = clamp(scaled_mul(clamp(Q_ONE + dxs, 32), d2y, 16)
                  + scaled_mul(clamp(Q_ONE + dys, 32), d2x, 16)
                  - 2 * scaled_mul(scaled_mul(dx, dy, 16), dxy, 16), 32);
      den = clamp(Q_ONE + dxs + dys, 32);
      hq = clamp((num <<< 16) / den, 32);
      hg = scaled_mul(longint'(st.weight), hq, SPEC_FRAC);
      ngx = clamp(-longint'(st.grad_x), 32);
      ngy = clamp(-longint'(st.grad_y), 32);
      ux = (ngx < 0) ? scaled_mul(ngx, dpx, 16) : scaled_mul(ngx, dmx, 16);
      uy = (ngy < 0) ? scaled_mul(ngy, dpy, 16) : scaled_mul(ngy, dmy, 16);
      up = clamp(ux + uy, 32);
      diff = clamp(hg - up, 32);
      nxt = clamp(c + scaled_mul(step_size, diff, SPEC_FRAC), 32);
      r.phi_next = nxt[31:0];
      r.saturated = clip_hit;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_q.size() == 0) begin
            report_mismatch("unexpected beat", rsp_phi_next, 0);
         end else begin
            update_type w;
            w = pending_q.pop_front();
            if (rsp_phi_next !== w.phi_next)
               report_mismatch("phi_next", rsp_phi_next, w.phi_next);
            if (rsp_saturated !== w.saturated)
               report_mismatch("saturated", rsp_saturated, w.saturated);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Receiver side: random stall, with one long hold-off when asked.
   initial begin
      int burst;
      int hold_left;
      burst = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request && hold_left == 0) begin
            hold_left = 300;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1;
         end else begin
            burst = pick_gap();
            rsp_stall <= (burst > 0);
            if (burst > 0) burst--;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_stencil(stim_row_type row);
      for (int i = 0; i < 9; i++) req_phi[i] <= row.st.phi[i];
      req_edge_weight <= row.st.weight;
      req_edge_grad_x <= row.st.grad_x;
      req_edge_grad_y <= row.st.grad_y;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      pending_q.push_back(row.fixed ? row.want : predict_update(row.st));
      @(negedge clock);
   endtask

   task automatic idle_gap(bit no_gap);
      int g;
      g = no_gap ? 0 : pick_gap();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic write_csr(csr_index_type idx, longint value);
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_INV_SPACING_X: spacing_x = value & 24'hFFFFFF;
         CSR_INV_SPACING_Y: spacing_y = value & 24'hFFFFFF;
         CSR_TIME_STEP:     step_size = value & 17'h1FFFF;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(3))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   function automatic stim_row_type random_row();
      stim_row_type r;
      int mode;
      logic signed [31:0] base;
      int spread;
      mode = $urandom_range(9);
      base = $urandom;
      spread = $urandom_range(24, 4);
      for (int i = 0; i < 9; i++) begin
         if (mode < 6) // taps from one base, each shifted by a random amount, plus small noise
            r.st.phi[i] = (base >>> $urandom_range(12, 0))
                          + ($signed($urandom) >>> (32 - spread));
         else if (mode < 8)
            r.st.phi[i] = $urandom;
         else
            r.st.phi[i] = pick_extreme();
      end
      r.st.weight = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
      if (mode < 6) begin
         r.st.grad_x = $signed($urandom) >>> $urandom_range(20, 8);
         r.st.grad_y = $signed($urandom) >>> $urandom_range(20, 8);
      end else begin
         r.st.grad_x = (mode == 8) ? pick_extreme() : $urandom;
         r.st.grad_y = (mode == 8) ? pick_extreme() : $urandom;
      end
      r.fixed = 0;
      r.want = '{0, 0};
      return r;
   endfunction

   function automatic stim_row_type make_row(logic [31:0] c, logic [31:0] w, logic [31:0] e,
                                             logic [31:0] n, logic [31:0] s, logic [31:0] diag,
                                             logic [16:0] g, logic [31:0] gx, logic [31:0] gy);
      stim_row_type r;
      r.st.phi[0] = c; r.st.phi[1] = w; r.st.phi[2] = e; r.st.phi[3] = n; r.st.phi[4] = s;
      r.st.phi[5] = diag; r.st.phi[6] = diag; r.st.phi[7] = ~diag; r.st.phi[8] = ~diag;
      r.st.weight = g;
      r.st.grad_x = gx;
      r.st.grad_y = gy;
      r.fixed = 0;
      r.want = '{0, 0};
      return r;
   endfunction

   stim_row_type directed [$];

   initial begin
      stim_row_type r;
      repeat (7) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // A flat surface does not move and clips nothing, whatever its level.
      r = make_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
      r.st.phi[7] = 0; r.st.phi[8] = 0;
      r.fixed = 1; r.want = '{32'sd0, 1'b0};
      directed.push_back(r);
      for (int i = 0; i < 9; i++) r.st.phi[i] = 32'h7FFFFFFF;
      r.st.weight = 17'h10000;
      r.want = '{32'sh7FFFFFFF, 1'b0};
      directed.push_back(r);
      for (int i = 0; i < 9; i++) r.st.phi[i] = 32'h80000000;
      r.st.weight = 17'h1FFFF;
      r.want = '{32'sh80000000, 1'b0};
      directed.push_back(r);
      // Negating the most negative gradient clips.
      r = make_row(0, 0, 0, 0, 0, 0, 0, 32'h80000000, 0);
      r.st.phi[7] = 0; r.st.phi[8] = 0;
      r.fixed = 1; r.want = '{32'sd0, 1'b1};
      directed.push_back(r);
      directed.push_back(make_row(0, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0,
                                  17'h10000, 0, 0));
      directed.push_back(make_row(0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  17'h10000, 32'h7FFFFFFF, 32'h80000000));
      directed.push_back(make_row(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
                                  32'h80000000, 32'h80000000, 17'h1FFFF, 0, 0));
      directed.push_back(make_row(32'h00010000, 0, 32'h00030000, 32'h00020000, 0,
                                  32'h00008000, 17'h08000, 32'h00001000, 32'hFFFFF000));
      directed.push_back(make_row(32'h00010000, 32'h00030000, 0, 0, 32'h00020000,
                                  32'hFFFF8000, 17'h0C000, 32'hFFFFF000, 32'h00001000));
      directed.push_back(make_row(32'h00100000, 32'h000F0000, 32'h00110000, 32'h00100000,
                                  32'h00100000, 32'h00004000, 17'h10000, 0, 32'h00020000));
      directed.push_back(make_row(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  32'h7FFFFFFF, 32'h80000000, 17'h10000,
                                  32'h80000000, 32'h7FFFFFFF));
      for (int i = 0; i < 6; i++) directed.push_back(random_row());

      foreach (directed[i]) begin
         send_stencil(directed[i]);
         idle_gap(0);
      end
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: ;
            1: begin
               write_csr(CSR_INV_SPACING_X, 1);
               write_csr(CSR_INV_SPACING_Y, 1);
               write_csr(CSR_TIME_STEP, 0);
            end
            2: begin
               write_csr(CSR_INV_SPACING_X, 24'hFFFFFF);
               write_csr(CSR_INV_SPACING_Y, 24'hFFFFFF);
               write_csr(CSR_TIME_STEP, 65536);
            end
            3: begin
               write_csr(CSR_INV_SPACING_X, 65536);
               write_csr(CSR_INV_SPACING_Y, 0);
               write_csr(CSR_TIME_STEP, 17'h1FFFF);
            end
            default: begin
               write_csr(CSR_INV_SPACING_X, $urandom_range(262144, 8192));
               write_csr(CSR_INV_SPACING_Y, $urandom_range(262144, 8192));
               write_csr(CSR_TIME_STEP, $urandom_range(17'h1FFFF));
            end
         endcase
         quiet = (ph == 5);
         // Back-to-back beats into a held-off receiver fill the pipeline.
         if (ph == 4) hold_request = 1;
         for (int k = 0; k < 205; k++) begin
            send_stencil(random_row());
            idle_gap(ph == 4 && k < 60);
         end
         drain();
      end

      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
